>>> src/cah_pkg.sv
// ----------------------------------------------------------------------------
// cah_pkg
// Shared widths, register map, reset values and types for the climate
// averaging block with hysteresis exhaust flags.
// ----------------------------------------------------------------------------
package cah_pkg;

  localparam int HUM_W       = 14;  // humidity sample
  localparam int TMP_W       = 15;  // temperature sample, signed
  localparam int AVG_W       = 15;  // corrected averages, signed
  localparam int THR_W       = 15;  // thresholds, signed
  localparam int CORR_W      = 11;  // corrections, unsigned
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int SAMPLES_DEF = 10;

  localparam logic signed [THR_W-1:0] HUMID_HIGH_ON_RST  = 15'sd8000;
  localparam logic signed [THR_W-1:0] HUMID_HIGH_OFF_RST = 15'sd7800;
  localparam logic signed [THR_W-1:0] HUMID_LOW_ON_RST   = 15'sd5000;
  localparam logic signed [THR_W-1:0] HUMID_LOW_OFF_RST  = 15'sd5200;
  localparam logic signed [THR_W-1:0] TEMP_ON_RST        = 15'sd3000;
  localparam logic signed [THR_W-1:0] TEMP_OFF_RST       = 15'sd2800;
  localparam logic [CORR_W-1:0]       TEMP_CORR_RST      = 11'd250;
  localparam logic [CORR_W-1:0]       HUMID_CORR_RST     = 11'd1000;

  typedef enum logic [2:0] {
    REG_HUMID_HIGH_ON  = 3'd0,
    REG_HUMID_HIGH_OFF = 3'd1,
    REG_HUMID_LOW_ON   = 3'd2,
    REG_HUMID_LOW_OFF  = 3'd3,
    REG_TEMP_ON        = 3'd4,
    REG_TEMP_OFF       = 3'd5,
    REG_TEMP_CORR      = 3'd6,
    REG_HUMID_CORR     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [THR_W-1:0] humid_high_on;
    logic signed [THR_W-1:0] humid_high_off;
    logic signed [THR_W-1:0] humid_low_on;
    logic signed [THR_W-1:0] humid_low_off;
    logic signed [THR_W-1:0] temp_on;
    logic signed [THR_W-1:0] temp_off;
    logic [CORR_W-1:0]       temp_correction;
    logic [CORR_W-1:0]       humid_correction;
  } cfg_t;

endpackage

>>> src/cah_in_if.sv
// ----------------------------------------------------------------------------
// cah_in_if
// Sample channel: one humidity and temperature pair per item.
// ----------------------------------------------------------------------------
interface cah_in_if;
  logic                             valid;
  logic                             ready;
  logic [cah_pkg::HUM_W-1:0]        humidity_sample;
  logic signed [cah_pkg::TMP_W-1:0] temperature_sample;

  modport source (output valid, humidity_sample, temperature_sample, input ready);
  modport sink   (input valid, humidity_sample, temperature_sample, output ready);
endinterface

>>> src/cah_out_if.sv
// ----------------------------------------------------------------------------
// cah_out_if
// Result channel: batch averages and exhaust flags.
// ----------------------------------------------------------------------------
interface cah_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cah_pkg::AVG_W-1:0] avg_humidity;
  logic signed [cah_pkg::AVG_W-1:0] avg_temperature;
  logic                             humid_high_flag;
  logic                             humid_low_flag;
  logic                             temp_flag;

  modport source (output valid, avg_humidity, avg_temperature, humid_high_flag,
                  humid_low_flag, temp_flag, input ready);
  modport sink   (input valid, avg_humidity, avg_temperature, humid_high_flag,
                  humid_low_flag, temp_flag, output ready);
endinterface

>>> src/cah_cfg_regs.sv
// ----------------------------------------------------------------------------
// cah_cfg_regs
// APB-style register file for thresholds and corrections.
// ----------------------------------------------------------------------------
module cah_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cah_pkg::ADDR_W-1:0]   paddr,
  input  logic [cah_pkg::DATA_W-1:0]   pwdata,
  output logic [cah_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output cah_pkg::cfg_t                cfg
);

  cah_pkg::cfg_t     cfg_r, cfg_nxt;
  cah_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = cah_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        cah_pkg::REG_HUMID_HIGH_ON:  cfg_nxt.humid_high_on    = pwdata[14:0];
        cah_pkg::REG_HUMID_HIGH_OFF: cfg_nxt.humid_high_off   = pwdata[14:0];
        cah_pkg::REG_HUMID_LOW_ON:   cfg_nxt.humid_low_on     = pwdata[14:0];
        cah_pkg::REG_HUMID_LOW_OFF:  cfg_nxt.humid_low_off    = pwdata[14:0];
        cah_pkg::REG_TEMP_ON:        cfg_nxt.temp_on          = pwdata[14:0];
        cah_pkg::REG_TEMP_OFF:       cfg_nxt.temp_off         = pwdata[14:0];
        cah_pkg::REG_TEMP_CORR:      cfg_nxt.temp_correction  = pwdata[10:0];
        cah_pkg::REG_HUMID_CORR:     cfg_nxt.humid_correction = pwdata[10:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cah_pkg::REG_HUMID_HIGH_ON:  prdata = 32'(cfg_r.humid_high_on);
      cah_pkg::REG_HUMID_HIGH_OFF: prdata = 32'(cfg_r.humid_high_off);
      cah_pkg::REG_HUMID_LOW_ON:   prdata = 32'(cfg_r.humid_low_on);
      cah_pkg::REG_HUMID_LOW_OFF:  prdata = 32'(cfg_r.humid_low_off);
      cah_pkg::REG_TEMP_ON:        prdata = 32'(cfg_r.temp_on);
      cah_pkg::REG_TEMP_OFF:       prdata = 32'(cfg_r.temp_off);
      cah_pkg::REG_TEMP_CORR:      prdata = {21'd0, cfg_r.temp_correction};
      cah_pkg::REG_HUMID_CORR:     prdata = {21'd0, cfg_r.humid_correction};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.humid_high_on    <= cah_pkg::HUMID_HIGH_ON_RST;
      cfg_r.humid_high_off   <= cah_pkg::HUMID_HIGH_OFF_RST;
      cfg_r.humid_low_on     <= cah_pkg::HUMID_LOW_ON_RST;
      cfg_r.humid_low_off    <= cah_pkg::HUMID_LOW_OFF_RST;
      cfg_r.temp_on          <= cah_pkg::TEMP_ON_RST;
      cfg_r.temp_off         <= cah_pkg::TEMP_OFF_RST;
      cfg_r.temp_correction  <= cah_pkg::TEMP_CORR_RST;
      cfg_r.humid_correction <= cah_pkg::HUMID_CORR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> src/cah_accum.sv
// ----------------------------------------------------------------------------
// cah_accum
// Batch accumulator: sums samples and hands the batch totals onward.
// ----------------------------------------------------------------------------
module cah_accum #(
  parameter int SAMPLES = cah_pkg::SAMPLES_DEF,
  parameter int HSUM_W  = cah_pkg::HUM_W + $clog2(SAMPLES),
  parameter int TSUM_W  = cah_pkg::TMP_W + 1 + $clog2(SAMPLES)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cah_pkg::HUM_W-1:0]        humidity_sample,
  input  logic signed [cah_pkg::TMP_W-1:0] temperature_sample,
  output logic                             tot_valid,
  input  logic                             tot_ready,
  output logic [HSUM_W-1:0]                hum_tot,
  output logic signed [TSUM_W-1:0]         tmp_tot
);

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [HSUM_W-1:0]        hsum_r, hsum_nxt;
  logic signed [TSUM_W-1:0] tsum_r, tsum_nxt;
  logic                     tot_valid_r, tot_valid_nxt;
  logic [HSUM_W-1:0]        hum_tot_r, hum_tot_nxt;
  logic signed [TSUM_W-1:0] tmp_tot_r, tmp_tot_nxt;
  logic                     last, accept;
  logic [HSUM_W-1:0]        hadd;
  logic signed [TSUM_W-1:0] tadd;

  assign last      = (cnt_r == LAST_CNT);
  // a batch-closing item needs the totals register free
  assign in_ready  = !last || !tot_valid_r || tot_ready;
  assign accept    = in_valid && in_ready;
  assign hadd      = hsum_r + HSUM_W'(humidity_sample);
  assign tadd      = tsum_r + TSUM_W'(temperature_sample);
  assign tot_valid = tot_valid_r;
  assign hum_tot   = hum_tot_r;
  assign tmp_tot   = tmp_tot_r;

  always_comb begin
    cnt_nxt       = cnt_r;
    hsum_nxt      = hsum_r;
    tsum_nxt      = tsum_r;
    hum_tot_nxt   = hum_tot_r;
    tmp_tot_nxt   = tmp_tot_r;
    tot_valid_nxt = tot_valid_r && !tot_ready;
    if (accept) begin
      if (last) begin
        cnt_nxt       = '0;
        hsum_nxt      = '0;
        tsum_nxt      = '0;
        hum_tot_nxt   = hadd;
        tmp_tot_nxt   = tadd;
        tot_valid_nxt = 1'b1;
      end else begin
        cnt_nxt  = cnt_r + 1'b1;
        hsum_nxt = hadd;
        tsum_nxt = tadd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hsum_r      <= '0;
      tsum_r      <= '0;
      tot_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      hsum_r      <= hsum_nxt;
      tsum_r      <= tsum_nxt;
      tot_valid_r <= tot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hum_tot_r <= hum_tot_nxt;
    tmp_tot_r <= tmp_tot_nxt;
  end

endmodule

>>> src/cah_scale.sv
// ----------------------------------------------------------------------------
// cah_scale
// Divides batch totals by the batch size with a reciprocal multiply.
// ----------------------------------------------------------------------------
module cah_scale #(
  parameter int SAMPLES = cah_pkg::SAMPLES_DEF,
  parameter int HSUM_W  = cah_pkg::HUM_W + $clog2(SAMPLES),
  parameter int TSUM_W  = cah_pkg::TMP_W + 1 + $clog2(SAMPLES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tot_valid,
  output logic                      tot_ready,
  input  logic [HSUM_W-1:0]         hum_tot,
  input  logic signed [TSUM_W-1:0]  tmp_tot,
  output logic                      q_valid,
  input  logic                      q_ready,
  output logic [cah_pkg::AVG_W-1:0] hum_q,
  output logic [cah_pkg::AVG_W-1:0] tmp_q,
  output logic                      tmp_neg
);

  // floor(x * m / 2^s) equals floor(x / SAMPLES) for every x below 2^n when
  // s = n + ceil(log2 SAMPLES) and m = ceil(2^s / SAMPLES)
  localparam int L      = $clog2(SAMPLES);
  localparam int TMAG_W = TSUM_W - 1;
  localparam int HS     = HSUM_W + L;
  localparam int TS     = TMAG_W + L;
  localparam longint unsigned HM =
    ((longint'(1) << HS) + longint'(SAMPLES) - 1) / longint'(SAMPLES);
  localparam longint unsigned TM =
    ((longint'(1) << TS) + longint'(SAMPLES) - 1) / longint'(SAMPLES);
  localparam logic [HSUM_W:0] HMUL = HM[HSUM_W:0];
  localparam logic [TMAG_W:0] TMUL = TM[TMAG_W:0];

  logic                          v_r;
  logic [cah_pkg::AVG_W-1:0]     hq_r, tq_r;
  logic                          neg_r;
  logic                          neg;
  logic [TSUM_W-1:0]             tabs;
  logic [TMAG_W-1:0]             tmag;
  logic [2*HSUM_W:0]             hprod;
  logic [2*TMAG_W:0]             tprod;

  assign tot_ready = !v_r || q_ready;
  assign neg       = tmp_tot[TSUM_W-1];
  assign tabs      = neg ? TSUM_W'(-tmp_tot) : TSUM_W'(tmp_tot);
  assign tmag      = tabs[TMAG_W-1:0];
  assign hprod     = (2*HSUM_W+1)'(hum_tot) * (2*HSUM_W+1)'(HMUL);
  assign tprod     = (2*TMAG_W+1)'(tmag) * (2*TMAG_W+1)'(TMUL);

  assign q_valid = v_r;
  assign hum_q   = hq_r;
  assign tmp_q   = tq_r;
  assign tmp_neg = neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (tot_ready) begin
      v_r <= tot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tot_ready && tot_valid) begin
      hq_r  <= hprod[HS +: cah_pkg::AVG_W];
      tq_r  <= tprod[TS +: cah_pkg::AVG_W];
      neg_r <= neg;
    end
  end

endmodule

>>> src/cah_flags.sv
// ----------------------------------------------------------------------------
// cah_flags
// Applies corrections, saturates, updates hysteresis flags, holds the result.
// ----------------------------------------------------------------------------
module cah_flags (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cah_pkg::cfg_t                    cfg,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  logic [cah_pkg::AVG_W-1:0]        hum_q,
  input  logic [cah_pkg::AVG_W-1:0]        tmp_q,
  input  logic                             tmp_neg,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cah_pkg::AVG_W-1:0] avg_humidity,
  output logic signed [cah_pkg::AVG_W-1:0] avg_temperature,
  output logic                             humid_high_flag,
  output logic                             humid_low_flag,
  output logic                             temp_flag
);

  function automatic logic signed [cah_pkg::AVG_W-1:0] sat15(
    input logic signed [16:0] v
  );
    if (v < -17'sd16384) begin
      return -15'sd16384;
    end else if (v > 17'sd16383) begin
      return 15'sd16383;
    end else begin
      return v[14:0];
    end
  endfunction

  logic                             v_r;
  logic signed [cah_pkg::AVG_W-1:0] h_r, t_r;
  logic                             high_r, high_nxt;
  logic                             low_r, low_nxt;
  logic                             tflag_r, tflag_nxt;
  logic signed [16:0]               tq_s, hv, tv;
  logic signed [cah_pkg::AVG_W-1:0] h_sat, t_sat;
  logic                             load;

  assign q_ready = !v_r || out_ready;
  assign load    = q_valid && q_ready;

  always_comb begin
    tq_s  = tmp_neg ? -$signed({2'b00, tmp_q}) : $signed({2'b00, tmp_q});
    hv    = $signed({2'b00, hum_q}) - $signed({6'd0, cfg.humid_correction});
    tv    = tq_s - $signed({6'd0, cfg.temp_correction});
    h_sat = sat15(hv);
    t_sat = sat15(tv);

    high_nxt  = high_r;
    low_nxt   = low_r;
    tflag_nxt = tflag_r;
    // humidity: one action per batch, highest priority first
    if (h_sat > cfg.humid_high_on) begin
      high_nxt = 1'b1;
    end else if (h_sat < cfg.humid_high_off && high_r) begin
      high_nxt = 1'b0;
    end else if (h_sat < cfg.humid_low_on) begin
      low_nxt = 1'b1;
    end else if (h_sat > cfg.humid_low_off && low_r) begin
      low_nxt = 1'b0;
    end
    if (t_sat > cfg.temp_on) begin
      tflag_nxt = 1'b1;
    end else if (t_sat < cfg.temp_off) begin
      tflag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      high_r  <= 1'b0;
      low_r   <= 1'b0;
      tflag_r <= 1'b0;
    end else begin
      if (q_ready) begin
        v_r <= q_valid;
      end
      if (load) begin
        high_r  <= high_nxt;
        low_r   <= low_nxt;
        tflag_r <= tflag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_r <= h_sat;
      t_r <= t_sat;
    end
  end

  // flag state changes only when a new result loads, so it doubles as output
  assign out_valid       = v_r;
  assign avg_humidity    = h_r;
  assign avg_temperature = t_r;
  assign humid_high_flag = high_r;
  assign humid_low_flag  = low_r;
  assign temp_flag       = tflag_r;

endmodule

>>> src/climate_average_hysteresis_flags.sv
// ----------------------------------------------------------------------------
// climate_average_hysteresis_flags
// Batch averaging of humidity and temperature with hysteresis exhaust flags.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; a batch-closing item stalls only when all
//   three downstream registers (totals, quotient, result) are full
// result path: the averages of a batch pass through the totals register, the
//   quotient register (reciprocal multiply) and the result register to out_ch
// reset: synchronous; clears counts, sums, flags and valids, loads defaults
module climate_average_hysteresis_flags #(
  parameter int SAMPLES = cah_pkg::SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cah_in_if.sink                     in_ch,
  cah_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cah_pkg::ADDR_W-1:0] paddr,
  input  logic [cah_pkg::DATA_W-1:0] pwdata,
  output logic [cah_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int HSUM_W = cah_pkg::HUM_W + $clog2(SAMPLES);
  localparam int TSUM_W = cah_pkg::TMP_W + 1 + $clog2(SAMPLES);

  cah_pkg::cfg_t             cfg;
  logic                      tot_valid, tot_ready;
  logic [HSUM_W-1:0]         hum_tot;
  logic signed [TSUM_W-1:0]  tmp_tot;
  logic                      q_valid, q_ready;
  logic [cah_pkg::AVG_W-1:0] hum_q, tmp_q;
  logic                      tmp_neg;

  cah_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cah_accum #(
    .SAMPLES (SAMPLES),
    .HSUM_W  (HSUM_W),
    .TSUM_W  (TSUM_W)
  ) u_accum (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .humidity_sample    (in_ch.humidity_sample),
    .temperature_sample (in_ch.temperature_sample),
    .tot_valid          (tot_valid),
    .tot_ready          (tot_ready),
    .hum_tot            (hum_tot),
    .tmp_tot            (tmp_tot)
  );

  cah_scale #(
    .SAMPLES (SAMPLES),
    .HSUM_W  (HSUM_W),
    .TSUM_W  (TSUM_W)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .tot_valid (tot_valid),
    .tot_ready (tot_ready),
    .hum_tot   (hum_tot),
    .tmp_tot   (tmp_tot),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .hum_q     (hum_q),
    .tmp_q     (tmp_q),
    .tmp_neg   (tmp_neg)
  );

  cah_flags u_flags (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .hum_q           (hum_q),
    .tmp_q           (tmp_q),
    .tmp_neg         (tmp_neg),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .avg_humidity    (out_ch.avg_humidity),
    .avg_temperature (out_ch.avg_temperature),
    .humid_high_flag (out_ch.humid_high_flag),
    .humid_low_flag  (out_ch.humid_low_flag),
    .temp_flag       (out_ch.temp_flag)
  );

endmodule
